// ----- hdl/rlepid_pkg.sv -----
// shared types and constants for the run-length pattern image decoder
// used by rlepid_ctrl, rlepid_datapath and rle_pattern_image_decoder_top
`timescale 1ns / 1ps

package rlepid_pkg;

  localparam int BYTE_W        = 8;
  localparam int IMG_W         = 21;           // image size and output position
  localparam int RUN_W         = 7;            // run counters, largest expansion is 81
  localparam int LEN_W         = 4;            // pattern length and index
  localparam int MAX_PATTERN   = 9;            // pattern bytes kept
  localparam int BYTE_LANES    = 4;            // byte fields carried per result
  localparam int DEF_OUT_LANES = 4;
  localparam int CNT_W         = 3;            // out_count field
  localparam int APB_AW        = 3;
  localparam int APB_DW        = 32;

  // control byte decode: bit 7 clear is a literal, 10 is a repeat, 11 a pattern
  localparam int KIND_BIT = 7;
  localparam int REP_BIT  = 6;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_BYTES = 1'b0;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CTRL,   // decode a control byte
    OP_LIT,    // pass one literal byte
    OP_REP,    // take the repeat value and set up the expansion
    OP_PAT,    // store one pattern byte, set up the expansion after the last
    OP_STEP    // pack one expanded byte
  } op_t;

  typedef struct packed {
    logic clear;   // image start on the accepted byte
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic img_complete;  // position at or past image size (after a start)
    logic lit_end;       // current literal byte ends the run or the image
    logic pat_last;      // current pattern byte is the last one
    logic exp_last;      // next packing step is the last of the expansion
    logic lane_flush;    // next packing step closes a result
    logic out_free;      // output register can take a result this cycle
  } stat_t;

endpackage

// ----- hdl/rle_pattern_image_decoder_top.sv -----
// top level of the run-length pattern image decoder: stream ports, apb
// register and field packing; depends on rlepid_pkg, rlepid_ctrl, rlepid_datapath
`timescale 1ns / 1ps

// Decodes a compressed image one stream byte per input transaction. A control
// byte 0vvvvvvv starts a literal run of v+1 bytes, 10cccccc is followed by a
// value byte repeated c+2 times, and 11LLLRRR is followed by L+2 pattern bytes
// that are played R+2 times. Decoding stops at image_bytes output bytes (apb
// register at address 0, reset value 1); later bytes are dropped until a byte
// arrives with the image start flag in s_tuser, which restarts the image.
// Timing: control, pattern and literal bytes do not hold the input off; a
// literal's one-byte result leaves the cycle after its transaction. A repeat
// value or last pattern byte holds the input off until its expansion, up to
// 81 bytes, is packed: the packer fills its output lanes one byte a cycle from
// a rotating pattern register, pausing while a closing group finds the output
// register busy; a full group of OUT_LANES bytes (or the run's tail) leaves as
// one result. An output register parts the two sides; the input stalls only
// while that register is full and not being taken, or while an expansion runs.
module rle_pattern_image_decoder_top
  import rlepid_pkg::*;
#(
  parameter int OUT_LANES = DEF_OUT_LANES
) (
  input  logic              clk,
  input  logic              rst,
  // compressed stream in
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] stream_byte
  input  logic              s_tuser,   // [0] image_start
  // decoded bytes out
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [7:0] out_byte0, [15:8] out_byte1,
                                       // [23:16] out_byte2, [31:24] out_byte3,
                                       // [34:32] out_count, [39:35] zero
  output logic              m_tlast,   // run_last
  output logic              m_tuser,   // [0] image_done
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [IMG_W-1:0] image_bytes;
  cmd_t             cmd;
  stat_t            stat;
  byte_t            ob0, ob1, ob2, ob3;
  logic [CNT_W-1:0] ocount;

  // register file: a single size register, low address bits ignored
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes <= IMG_W'(1);
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == REG_IMAGE_BYTES)) begin
      image_bytes <= pwdata[IMG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IMAGE_BYTES) ? APB_DW'(image_bytes) : '0;

  // state machine: byte class and run phase
  rlepid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_start (s_tuser),
    .in_byte  (s_tdata),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // counters, pattern store, lane packer and output register
  rlepid_datapath #(
    .OUT_LANES (OUT_LANES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .image_bytes (image_bytes),
    .in_byte     (s_tdata),
    .in_start    (s_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte0   (ob0),
    .out_byte1   (ob1),
    .out_byte2   (ob2),
    .out_byte3   (ob3),
    .out_count   (ocount),
    .out_last    (m_tlast),
    .out_done    (m_tuser)
  );

  // result fields packed from the lowest bit up
  assign m_tdata = {5'b0, ocount, ob3, ob2, ob1, ob0};

endmodule

// ----- hdl/rlepid_ctrl.sv -----
// controller state machine of the run-length pattern image decoder
// depends on rlepid_pkg; drives rlepid_datapath through cmd_t, reads stat_t
`timescale 1ns / 1ps

module rlepid_ctrl
  import rlepid_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_start,
  input  byte_t in_byte,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_CTRL,
    ST_LIT,
    ST_REP,
    ST_PAT,
    ST_EXPAND
  } state_t;

  state_t state;
  state_t state_next;
  state_t base;
  logic   accept;

  always_comb begin
    in_ready   = (state != ST_EXPAND) && stat.out_free;
    accept     = in_valid && in_ready;
    base       = in_start ? ST_CTRL : state;
    cmd.clear  = accept && in_start;
    cmd.op     = OP_NONE;
    state_next = state;
    if (state == ST_EXPAND) begin
      if (stat.out_free || !stat.lane_flush) begin
        cmd.op = OP_STEP;
        if (stat.exp_last) begin
          state_next = ST_CTRL;
        end
      end
    end else if (accept) begin
      state_next = base;
      if (!stat.img_complete) begin
        unique case (base)
          ST_CTRL: begin
            cmd.op = OP_CTRL;
            if (!in_byte[KIND_BIT]) begin
              state_next = ST_LIT;
            end else if (!in_byte[REP_BIT]) begin
              state_next = ST_REP;
            end else begin
              state_next = ST_PAT;
            end
          end
          ST_LIT: begin
            cmd.op = OP_LIT;
            if (stat.lit_end) begin
              state_next = ST_CTRL;
            end
          end
          ST_REP: begin
            cmd.op     = OP_REP;
            state_next = ST_EXPAND;
          end
          ST_PAT: begin
            cmd.op = OP_PAT;
            if (stat.pat_last) begin
              state_next = ST_EXPAND;
            end
          end
          default: begin
            state_next = ST_CTRL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CTRL;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/rlepid_datapath.sv -----
// datapath of the run-length pattern image decoder: run counters, pattern
// rotator, lane packer and output register; depends on rlepid_pkg
`timescale 1ns / 1ps

module rlepid_datapath
  import rlepid_pkg::*;
#(
  parameter int OUT_LANES = DEF_OUT_LANES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IMG_W-1:0] image_bytes,
  input  byte_t            in_byte,
  input  logic             in_start,
  input  cmd_t             cmd,
  output stat_t            stat,
  output logic             out_valid,
  input  logic             out_ready,
  output byte_t            out_byte0,
  output byte_t            out_byte1,
  output byte_t            out_byte2,
  output byte_t            out_byte3,
  output logic [CNT_W-1:0] out_count,
  output logic             out_last,
  output logic             out_done
);

  localparam int LANE_W = $clog2(OUT_LANES) + 1;

  // control state
  logic [IMG_W-1:0]  pos;
  logic [RUN_W-1:0]  run_cnt;     // literal bytes left, repeat count or pattern fill
  logic [LEN_W-1:0]  pat_len;
  logic [RUN_W-1:0]  rem;         // expanded bytes still to pack
  logic [LANE_W-1:0] lane_cnt;

  // payload
  byte_t             pat [MAX_PATTERN];
  byte_t             pat_next [MAX_PATTERN];
  byte_t             lanes [BYTE_LANES];
  byte_t             lanes_m [BYTE_LANES];
  logic [RUN_W-1:0]  pat_total;
  logic [LEN_W-1:0]  rot_last;
  logic              exp_done;

  logic [IMG_W-1:0]  pos_eff;
  logic [IMG_W-1:0]  left;
  logic [RUN_W-1:0]  run_total;
  logic              fits_end;
  logic [RUN_W-1:0]  run_n;
  logic [LANE_W:0]   cnt_wide;
  logic              setup;
  logic              out_load;    // a result enters the output register

  always_comb begin
    pos_eff   = in_start ? '0 : pos;
    left      = image_bytes - pos;
    run_total = (cmd.op == OP_PAT) ? pat_total : run_cnt;
    fits_end  = {{(IMG_W-RUN_W){1'b0}}, run_total} >= left;
    run_n     = fits_end ? left[RUN_W-1:0] : run_total;
    setup     = (cmd.op == OP_REP) || ((cmd.op == OP_PAT) && stat.pat_last);
    cnt_wide  = {1'b0, lane_cnt} + (LANE_W+1)'(1);

    stat.img_complete = pos_eff >= image_bytes;
    stat.lit_end      = (run_cnt == '0) || (left == IMG_W'(1));
    stat.pat_last     = (run_cnt[LEN_W-1:0] + LEN_W'(1)) >= pat_len;
    stat.exp_last     = rem == RUN_W'(1);
    stat.lane_flush   = (lane_cnt == LANE_W'(OUT_LANES - 1)) || stat.exp_last;
    stat.out_free     = !out_valid || out_ready;

    out_load = (cmd.op == OP_LIT) || ((cmd.op == OP_STEP) && stat.lane_flush);

    for (int j = 0; j < BYTE_LANES; j++) begin
      lanes_m[j] = (32'(lane_cnt) == j) ? pat[0] : lanes[j];
    end

    // rotate the active part of the pattern so that entry 0 is always next
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat_next[i] = pat[i];
      if (cmd.op == OP_STEP) begin
        if (LEN_W'(i) == rot_last) begin
          pat_next[i] = pat[0];
        end else if (LEN_W'(i) < rot_last) begin
          pat_next[i] = pat[(i + 1) % MAX_PATTERN];
        end
      end else if (cmd.op == OP_REP) begin
        if (i == 0) begin
          pat_next[i] = in_byte;
        end
      end else if (cmd.op == OP_PAT) begin
        if (run_cnt == RUN_W'(i)) begin
          pat_next[i] = in_byte;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
      run_cnt   <= '0;
      pat_len   <= '0;
      rem       <= '0;
      lane_cnt  <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.clear) begin
        pos <= '0;
      end
      unique case (cmd.op)
        OP_NONE: begin
          if (cmd.clear) begin
            run_cnt <= '0;
            pat_len <= '0;
          end
        end
        OP_CTRL: begin
          if (!in_byte[KIND_BIT]) begin
            run_cnt <= in_byte[RUN_W-1:0];
          end else if (!in_byte[REP_BIT]) begin
            run_cnt <= RUN_W'(in_byte[5:0]) + RUN_W'(2);
          end else begin
            pat_len <= LEN_W'(in_byte[5:3]) + LEN_W'(2);
            run_cnt <= '0;
          end
        end
        OP_LIT: begin
          if (run_cnt != '0) begin
            run_cnt <= run_cnt - RUN_W'(1);
          end
          pos <= pos + IMG_W'(1);
        end
        OP_REP: begin
          run_cnt  <= '0;
          rem      <= run_n;
          lane_cnt <= '0;
          pos      <= pos + IMG_W'(run_n);
        end
        OP_PAT: begin
          if (stat.pat_last) begin
            run_cnt  <= '0;
            rem      <= run_n;
            lane_cnt <= '0;
            pos      <= pos + IMG_W'(run_n);
          end else begin
            run_cnt <= run_cnt + RUN_W'(1);
          end
        end
        OP_STEP: begin
          rem <= rem - RUN_W'(1);
          if (stat.lane_flush) begin
            lane_cnt <= '0;
          end else begin
            lane_cnt <= lane_cnt + LANE_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pat <= pat_next;
    if ((cmd.op == OP_CTRL) && in_byte[KIND_BIT] && in_byte[REP_BIT]) begin
      pat_total <= (RUN_W'(in_byte[5:3]) + RUN_W'(2))
                 * (RUN_W'(in_byte[2:0]) + RUN_W'(2));
    end
    if (setup) begin
      rot_last <= (cmd.op == OP_REP) ? '0 : pat_len - LEN_W'(1);
      exp_done <= fits_end;
      for (int j = 0; j < BYTE_LANES; j++) begin
        lanes[j] <= '0;
      end
    end
    if (cmd.op == OP_LIT) begin
      out_byte0 <= in_byte;
      out_byte1 <= '0;
      out_byte2 <= '0;
      out_byte3 <= '0;
      out_count <= CNT_W'(1);
      out_last  <= 1'b1;
      out_done  <= left == IMG_W'(1);
    end
    if (cmd.op == OP_STEP) begin
      if (stat.lane_flush) begin
        out_byte0 <= lanes_m[0];
        out_byte1 <= lanes_m[1];
        out_byte2 <= lanes_m[2];
        out_byte3 <= lanes_m[3];
        out_count <= CNT_W'(cnt_wide);
        out_last  <= stat.exp_last;
        out_done  <= exp_done && stat.exp_last;
        for (int j = 0; j < BYTE_LANES; j++) begin
          lanes[j] <= '0;
        end
      end else begin
        lanes <= lanes_m;
      end
    end
  end

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_STEP) |-> (rem != '0))
    else $error("packing step with no expanded bytes left");

  a_lane_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(lane_cnt) < OUT_LANES)
    else $error("lane counter past lane count");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> out_last)
    else $error("image end flagged on a result that is not the last of its byte");

  a_single_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_count == CNT_W'(1)))
      |-> ((out_byte1 == '0) && (out_byte2 == '0) && (out_byte3 == '0)))
    else $error("unused lanes not zero");

endmodule
